/* rtl/ueravg_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger with moving average.
package ueravg_pkg;

	localparam int DIST_W   = 22;
	localparam int PULSE_W  = 16;
	localparam int TRIG_W   = 8;
	localparam int SCALE_W  = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int PROD_W   = PULSE_W + SCALE_W;

	localparam int AVG_TAPS_DEF = 5;

	localparam logic [DIST_W-1:0]  DIST_MAX   = '1;
	localparam logic [PULSE_W-1:0] PULSE_MAX  = '1;
	localparam logic [TRIG_W-1:0]  TRIG_MAX   = '1;

	localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST  = 8'd98;
	localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 16'd11509;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE = 1'd1;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

	typedef struct packed {
		logic              trigger_level;
		logic              done_res;
		logic [DIST_W-1:0] raw_distance;
		logic [DIST_W-1:0] filtered_distance;
		logic              busy_res;
	} out_item_t;

endpackage

/* rtl/ueravg_tap_cell.sv */
// One sample cell of the averaging chain: takes its neighbor's sample on a shift.
module ueravg_tap_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic [ueravg_pkg::DIST_W-1:0] d,
	output logic [ueravg_pkg::DIST_W-1:0] q
);

	logic [ueravg_pkg::DIST_W-1:0] data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

/* rtl/ueravg_ring.sv */
// Sample chain with running sum and fill count for the moving average.
module ueravg_ring #(
	parameter int AVG_TAPS = ueravg_pkg::AVG_TAPS_DEF,
	parameter int SUM_W    = ueravg_pkg::DIST_W + $clog2(ueravg_pkg::AVG_TAPS_DEF)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [ueravg_pkg::DIST_W-1:0] raw,
	output logic [SUM_W-1:0]              sum_next,
	output logic                          use_avg
);

	localparam int FillW = $clog2(AVG_TAPS + 1);

	logic [ueravg_pkg::DIST_W-1:0] tap   [AVG_TAPS];
	logic [ueravg_pkg::DIST_W-1:0] tap_in[AVG_TAPS];
	logic [SUM_W-1:0]              sum_q;
	logic [FillW-1:0]              fill_q;
	logic [FillW-1:0]              fill_next;

	assign tap_in[0] = raw;

	for (genvar i = 0; i < AVG_TAPS; i++) begin : g_tap
		if (i > 0) begin : g_link
			assign tap_in[i] = tap[i-1];
		end
		ueravg_tap_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (push),
			.d      (tap_in[i]),
			.q      (tap[i])
		);
	end

	// last cell holds the oldest sample, which drops out on a push
	assign sum_next  = sum_q - SUM_W'(tap[AVG_TAPS-1]) + SUM_W'(raw);
	assign fill_next = (fill_q == FillW'(AVG_TAPS)) ? fill_q : fill_q + 1'b1;
	assign use_avg   = (fill_next == FillW'(AVG_TAPS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
		end else if (push) begin
			sum_q  <= sum_next;
			fill_q <= fill_next;
		end
	end

endmodule

/* rtl/ueravg_out_fifo.sv */
// Result queue between the compute pipeline and the output channel.
module ueravg_out_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  ueravg_pkg::out_item_t wr_item,
	input  logic                  rd_en,
	output ueravg_pkg::out_item_t rd_item,
	output logic                  not_empty
);

	localparam int Aw = ueravg_pkg::FIFO_AW;

	ueravg_pkg::out_item_t mem [ueravg_pkg::FIFO_DEPTH];
	logic [Aw:0]           wr_ptr_q;
	logic [Aw:0]           rd_ptr_q;
	logic                  full;

	assign not_empty = (wr_ptr_q != rd_ptr_q);
	assign full      = (wr_ptr_q[Aw] != rd_ptr_q[Aw]) && (wr_ptr_q[Aw-1:0] == rd_ptr_q[Aw-1:0]);
	assign rd_item   = mem[rd_ptr_q[Aw-1:0]];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q[Aw-1:0]] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("result queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> not_empty) else $error("result queue read while empty");
`endif

endmodule

/* rtl/ultrasonic_echo_ranger_avg.sv */
// Ultrasonic echo ranger: trigger/echo sequencer, distance scaling, moving average.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | start_req, echo_level
//  out     | output    | out_valid/out_stall| trigger_level, done_res, raw_distance,
//          |           |                    | filtered_distance, busy_res
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
//
// One input transfer per cycle while in_stall is low; each gives one output transfer.
// Each item passes the sequencer register, three compute stages (scale multiply,
// sample chain update, reciprocal multiply for the average) and the result queue write.
// Input stall rises only when eight items are in flight or queued.
// Reset clears the sequencer, the sample chain, the running sum and the last distances.
module ultrasonic_echo_ranger_avg #(
	parameter int AVG_TAPS = ueravg_pkg::AVG_TAPS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                start_req,
	input  logic                                echo_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                trigger_level,
	output logic                                done_res,
	output logic [ueravg_pkg::DIST_W-1:0]       raw_distance,
	output logic [ueravg_pkg::DIST_W-1:0]       filtered_distance,
	output logic                                busy_res,
	input  logic                                cfg_we,
	input  logic [ueravg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ueravg_pkg::CFG_W-1:0]        cfg_data
);

	localparam int DistW  = ueravg_pkg::DIST_W;
	localparam int PulseW = ueravg_pkg::PULSE_W;
	localparam int TrigW  = ueravg_pkg::TRIG_W;
	localparam int ScaleW = ueravg_pkg::SCALE_W;
	localparam int ProdW  = ueravg_pkg::PROD_W;
	localparam int Log    = $clog2(AVG_TAPS);
	localparam int SumW   = DistW + Log;
	localparam int Shift  = SumW + Log;
	localparam int QW     = 2 * SumW + 1;
	// round-up reciprocal: exact quotient for every sum below 2**SumW
	localparam longint unsigned RecipFull =
		((64'd1 << Shift) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS);
	localparam logic [SumW:0] Recip = RecipFull[SumW:0];

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_TRIG  = 2'd1;
	localparam logic [1:0] PH_WAIT  = 2'd2;
	localparam logic [1:0] PH_COUNT = 2'd3;

	// configuration
	logic [TrigW-1:0]  trigger_ticks_q;
	logic [ScaleW-1:0] distance_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q  <= ueravg_pkg::TRIGGER_TICKS_RST;
			distance_scale_q <= ueravg_pkg::DISTANCE_SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ueravg_pkg::CFG_TRIGGER_TICKS: begin
					trigger_ticks_q <= cfg_data[TrigW-1:0];
				end
				ueravg_pkg::CFG_DISTANCE_SCALE: begin
					distance_scale_q <= cfg_data[ScaleW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer
	logic              in_acc;
	logic              out_acc;
	logic [1:0]        phase_q, phase_d, phase_eff;
	logic [TrigW-1:0]  tcount_q, tcount_d, tcount_cur, tcount_inc;
	logic [PulseW-1:0] pcount_q, pcount_d, pcount_cur;
	logic              trig_c, busy_c, done_c;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_comb begin
		phase_eff  = phase_q;
		tcount_cur = tcount_q;
		pcount_cur = pcount_q;
		if (phase_q == PH_IDLE && start_req) begin
			phase_eff  = PH_TRIG;
			tcount_cur = '0;
			pcount_cur = '0;
		end
		phase_d    = phase_eff;
		tcount_d   = tcount_cur;
		pcount_d   = pcount_cur;
		tcount_inc = (tcount_cur != ueravg_pkg::TRIG_MAX) ? tcount_cur + 1'b1 : tcount_cur;
		trig_c     = 1'b0;
		busy_c     = 1'b0;
		done_c     = 1'b0;
		unique case (phase_eff)
			PH_IDLE: begin
			end
			PH_TRIG: begin
				trig_c   = 1'b1;
				busy_c   = 1'b1;
				tcount_d = tcount_inc;
				if (tcount_inc >= trigger_ticks_q) begin
					phase_d = PH_WAIT;
				end
			end
			PH_WAIT: begin
				busy_c = 1'b1;
				if (echo_level) begin
					pcount_d = PulseW'(1);
					phase_d  = PH_COUNT;
				end
			end
			PH_COUNT: begin
				busy_c = 1'b1;
				if (echo_level) begin
					if (pcount_cur != ueravg_pkg::PULSE_MAX) begin
						pcount_d = pcount_cur + 1'b1;
					end
				end else begin
					done_c  = 1'b1;
					phase_d = PH_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tcount_q <= '0;
			pcount_q <= '0;
		end else if (in_acc) begin
			phase_q  <= phase_d;
			tcount_q <= tcount_d;
			pcount_q <= pcount_d;
		end
	end

	// pipeline valids
	logic v_s1, v_s2, v_s3, v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: sequencer outputs
	logic              trig_s1, busy_s1, done_s1;
	logic [PulseW-1:0] pulse_s1;

	always_ff @(posedge clk) begin
		trig_s1  <= trig_c;
		busy_s1  <= busy_c;
		done_s1  <= done_c;
		pulse_s1 <= pcount_cur;
	end

	// stage 2: scale multiply
	logic             trig_s2, busy_s2, done_s2;
	logic [ProdW-1:0] prod_s2;

	always_ff @(posedge clk) begin
		trig_s2 <= trig_s1;
		busy_s2 <= busy_s1;
		done_s2 <= done_s1;
		prod_s2 <= ProdW'(pulse_s1) * ProdW'(distance_scale_q);
	end

	logic [ProdW-9:0] dist_wide;
	logic [DistW-1:0] raw_new;
	logic [SumW-1:0]  sum_next;
	logic             use_avg;

	assign dist_wide = prod_s2[ProdW-1:8];
	assign raw_new   = (dist_wide > (ProdW-8)'(ueravg_pkg::DIST_MAX)) ?
		ueravg_pkg::DIST_MAX : dist_wide[DistW-1:0];

	ueravg_ring #(
		.AVG_TAPS (AVG_TAPS),
		.SUM_W    (SumW)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (v_s2 && done_s2),
		.raw      (raw_new),
		.sum_next (sum_next),
		.use_avg  (use_avg)
	);

	// stage 3: chain updated, sum captured
	logic             trig_s3, busy_s3, done_s3, avg_s3;
	logic [DistW-1:0] raw_s3;
	logic [SumW-1:0]  sum_s3;

	always_ff @(posedge clk) begin
		trig_s3 <= trig_s2;
		busy_s3 <= busy_s2;
		done_s3 <= done_s2;
		avg_s3  <= use_avg;
		raw_s3  <= raw_new;
		sum_s3  <= sum_next;
	end

	// stage 4: reciprocal multiply for the average
	logic             trig_s4, busy_s4, done_s4, avg_s4;
	logic [DistW-1:0] raw_s4;
	logic [QW-1:0]    qprod_s4;

	always_ff @(posedge clk) begin
		trig_s4  <= trig_s3;
		busy_s4  <= busy_s3;
		done_s4  <= done_s3;
		avg_s4   <= avg_s3;
		raw_s4   <= raw_s3;
		qprod_s4 <= QW'(sum_s3) * QW'(Recip);
	end

	logic [DistW-1:0] filt_new;
	logic [DistW-1:0] last_raw_q, last_filt_q;

	assign filt_new = avg_s4 ? qprod_s4[Shift +: DistW] : raw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q  <= '0;
			last_filt_q <= '0;
		end else if (v_s4 && done_s4) begin
			last_raw_q  <= raw_s4;
			last_filt_q <= filt_new;
		end
	end

	ueravg_pkg::out_item_t wr_item, rd_item;

	always_comb begin
		wr_item.trigger_level     = trig_s4;
		wr_item.done_res          = done_s4;
		wr_item.raw_distance      = done_s4 ? raw_s4 : last_raw_q;
		wr_item.filtered_distance = done_s4 ? filt_new : last_filt_q;
		wr_item.busy_res          = busy_s4;
	end

	ueravg_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (v_s4),
		.wr_item   (wr_item),
		.rd_en     (out_acc),
		.rd_item   (rd_item),
		.not_empty (out_valid)
	);

	assign trigger_level     = rd_item.trigger_level;
	assign done_res          = rd_item.done_res;
	assign raw_distance      = rd_item.raw_distance;
	assign filtered_distance = rd_item.filtered_distance;
	assign busy_res          = rd_item.busy_res;

	// items in the pipeline plus items queued; queue can always take what is in flight
	logic [ueravg_pkg::CREDIT_W-1:0] credit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (in_acc && !out_acc) begin
			credit_q <= credit_q + 1'b1;
		end else if (!in_acc && out_acc) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	assign in_stall = (credit_q >= ueravg_pkg::CREDIT_W'(ueravg_pkg::FIFO_DEPTH));

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= ueravg_pkg::CREDIT_W'(ueravg_pkg::FIFO_DEPTH))
		else $error("in-flight count beyond queue depth");

	a_done_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && phase_q == PH_COUNT && !echo_level |=> v_s1 && done_s1)
		else $error("echo fall did not complete the measurement");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && done_s2 |-> $past(v_s1 && done_s1))
		else $error("completion lost between stages");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && trig_s1 |-> busy_s1)
		else $error("trigger high outside a measurement");
`endif

endmodule

/* tb/echo_range_checker.sv */
// Scoreboard for the echo ranger: predicts every output transfer and compares it field by field.
module echo_range_checker #(
	parameter int TAPS = ueravg_pkg::AVG_TAPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             start_req,
	input  logic                             echo_level,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic                             trigger_level,
	input  logic                             done_res,
	input  logic [ueravg_pkg::DIST_W-1:0]    raw_distance,
	input  logic [ueravg_pkg::DIST_W-1:0]    filtered_distance,
	input  logic                             busy_res,
	input  logic                             cfg_we,
	input  logic [ueravg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ueravg_pkg::CFG_W-1:0]     cfg_data,
	output int                               fail_count,
	output int                               pending
);

	typedef enum logic [1:0] {RNG_IDLE, RNG_TRIGGER, RNG_WAIT, RNG_COUNT} ranger_phase_t;

	localparam int PRINT_CAP = 40;

	ranger_phase_t                   seq_phase = RNG_IDLE;
	logic [ueravg_pkg::TRIG_W-1:0]   trig_len_cfg = ueravg_pkg::TRIGGER_TICKS_RST;
	logic [ueravg_pkg::SCALE_W-1:0]  scale_cfg = ueravg_pkg::DISTANCE_SCALE_RST;
	logic [ueravg_pkg::TRIG_W-1:0]   trig_cnt = '0;
	logic [ueravg_pkg::PULSE_W-1:0]  pulse_cnt = '0;
	logic [ueravg_pkg::DIST_W-1:0]   ring [TAPS];
	int                              ring_ptr = 0;
	int                              ring_fill = 0;
	logic [ueravg_pkg::DIST_W+4:0]   ring_total = '0;
	logic [ueravg_pkg::DIST_W-1:0]   last_raw = '0;
	logic [ueravg_pkg::DIST_W-1:0]   last_avg = '0;
	ueravg_pkg::out_item_t           expected_ticks[$];
	int                              mismatches = 0;

	initial begin
		fail_count = 0;
		pending = 0;
		foreach (ring[i]) ring[i] = '0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// one time-base tick of the sequencer, scaler and averager
	task automatic predict_tick(input logic start, input logic echo,
			output ueravg_pkg::out_item_t res);
		logic [ueravg_pkg::PROD_W-1:0] prod;
		logic [ueravg_pkg::DIST_W-1:0] dist_val;
		res = '0;
		if (seq_phase == RNG_IDLE && start) begin
			seq_phase = RNG_TRIGGER;
			trig_cnt = '0;
			pulse_cnt = '0;
		end
		case (seq_phase)
			RNG_TRIGGER: begin
				res.busy_res = 1'b1;
				res.trigger_level = 1'b1;
				if (trig_cnt != ueravg_pkg::TRIG_MAX)
					trig_cnt++;
				// a zero length compares true at once: one trigger tick
				if (trig_cnt >= trig_len_cfg)
					seq_phase = RNG_WAIT;
			end
			RNG_WAIT: begin
				res.busy_res = 1'b1;
				if (echo) begin
					pulse_cnt = 1;
					seq_phase = RNG_COUNT;
				end
			end
			RNG_COUNT: begin
				res.busy_res = 1'b1;
				if (echo) begin
					if (pulse_cnt != ueravg_pkg::PULSE_MAX)
						pulse_cnt++;
				end else begin
					prod = pulse_cnt * scale_cfg;
					dist_val = ((prod >> 8) > ueravg_pkg::DIST_MAX) ? ueravg_pkg::DIST_MAX
						: prod[ueravg_pkg::DIST_W+7:8];
					ring_total = ring_total - ring[ring_ptr] + dist_val;
					ring[ring_ptr] = dist_val;
					ring_ptr = (ring_ptr == TAPS - 1) ? 0 : ring_ptr + 1;
					if (ring_fill < TAPS)
						ring_fill++;
					last_raw = dist_val;
					last_avg = (ring_fill >= TAPS) ?
						ueravg_pkg::DIST_W'(ring_total / TAPS) : dist_val;
					res.done_res = 1'b1;
					seq_phase = RNG_IDLE;
				end
			end
			default: ;
		endcase
		res.raw_distance = last_raw;
		res.filtered_distance = last_avg;
	endtask

	always @(posedge clk or negedge arst_n) begin
		ueravg_pkg::out_item_t want;
		if (!arst_n) begin
			seq_phase = RNG_IDLE;
			trig_len_cfg = ueravg_pkg::TRIGGER_TICKS_RST;
			scale_cfg = ueravg_pkg::DISTANCE_SCALE_RST;
			trig_cnt = '0;
			pulse_cnt = '0;
			foreach (ring[i]) ring[i] = '0;
			ring_ptr = 0;
			ring_fill = 0;
			ring_total = '0;
			last_raw = '0;
			last_avg = '0;
			expected_ticks.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_ticks.size() == 0) begin
					report_mismatch("output transfer with none pending", raw_distance, 0);
				end else begin
					want = expected_ticks.pop_front();
					check_field("trigger_level", trigger_level, want.trigger_level);
					check_field("done_res", done_res, want.done_res);
					check_field("raw_distance", raw_distance, want.raw_distance);
					check_field("filtered_distance", filtered_distance,
						want.filtered_distance);
					check_field("busy_res", busy_res, want.busy_res);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					ueravg_pkg::CFG_TRIGGER_TICKS:
						trig_len_cfg = cfg_data[ueravg_pkg::TRIG_W-1:0];
					ueravg_pkg::CFG_DISTANCE_SCALE:
						scale_cfg = cfg_data[ueravg_pkg::SCALE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				predict_tick(start_req, echo_level, want);
				expected_ticks.push_back(want);
			end
		end
		pending <= expected_ticks.size();
		fail_count <= mismatches;
	end

endmodule

/* tb/ultrasonic_echo_ranger_avg_tb.sv */
// Testbench top for the echo ranger: clock, reset, stimulus, output stalls and verdict.
module ultrasonic_echo_ranger_avg_tb;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             start_req = 1'b0;
	logic                             echo_level = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic                             trigger_level;
	logic                             done_res;
	logic [ueravg_pkg::DIST_W-1:0]    raw_distance;
	logic [ueravg_pkg::DIST_W-1:0]    filtered_distance;
	logic                             busy_res;
	logic                             cfg_we = 1'b0;
	logic [ueravg_pkg::CFG_IDX_W-1:0] cfg_index = ueravg_pkg::CFG_TRIGGER_TICKS;
	logic [ueravg_pkg::CFG_W-1:0]     cfg_data = '0;

	int fails;
	int pending_ticks;

	int burst_left = 0;
	int trig_now = ueravg_pkg::TRIGGER_TICKS_RST;
	int ticks_sent = 0;

	always #5 clk = ~clk;

	ultrasonic_echo_ranger_avg dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger_level(trigger_level),
		.done_res(done_res),
		.raw_distance(raw_distance),
		.filtered_distance(filtered_distance),
		.busy_res(busy_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	echo_range_checker scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.start_req(start_req),
		.echo_level(echo_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.trigger_level(trigger_level),
		.done_res(done_res),
		.raw_distance(raw_distance),
		.filtered_distance(filtered_distance),
		.busy_res(busy_res),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fails),
		.pending(pending_ticks)
	);

	// one tick transfer; bursts of random length with random gaps in between
	task automatic send_tick(input logic s, input logic e);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		start_req <= s;
		echo_level <= e;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	// start, trigger window, echo wait, echo high, echo fall; starts inside are ignored
	task automatic measure_echo(input int wait_len, input int high_len);
		int trig_eff;
		trig_eff = (trig_now == 0) ? 1 : trig_now;
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat (trig_eff - 1) send_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
		repeat (wait_len) send_tick($urandom_range(0, 3) == 0, 1'b0);
		repeat (high_len) send_tick($urandom_range(0, 3) == 0, 1'b1);
		send_tick($urandom_range(0, 3) == 0, 1'b0);
	endtask

	// drain everything in flight, then write both registers
	task automatic program_ranger(input int trig, input int scale);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_ticks != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ueravg_pkg::CFG_TRIGGER_TICKS;
		// upper byte is junk; only the low byte counts
		cfg_data <= {8'($urandom_range(0, 255)), 8'(trig)};
		@(posedge clk);
		cfg_index <= ueravg_pkg::CFG_DISTANCE_SCALE;
		cfg_data <= 16'(scale);
		@(posedge clk);
		cfg_we <= 1'b0;
		trig_now = trig & 8'hFF;
	endtask

	task automatic random_phase(input int trig, input int scale, input int quota);
		int base;
		program_ranger(trig, scale);
		base = ticks_sent;
		while (ticks_sent - base < quota) begin
			if ($urandom_range(0, 9) < 8)
				measure_echo(($urandom_range(0, 4) == 0) ? $urandom_range(7, 60)
						: $urandom_range(0, 6),
					($urandom_range(0, 7) == 0) ? $urandom_range(31, 300)
						: $urandom_range(1, 30));
			else
				repeat ($urandom_range(1, 8)) send_tick(1'b0, 1'($urandom_range(0, 1)));
		end
	endtask

	// output stalls: free, light and heavy stretches, plus long hold-offs that back up the input
	initial begin
		int seg;
		int len;
		int mode;
		seg = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			seg++;
			if (seg == 4 || $urandom_range(0, 15) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(40, 80)) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 2);
				len = $urandom_range(10, 60);
				repeat (len) begin
					if (mode == 0)
						out_stall <= 1'b0;
					else if (mode == 1)
						out_stall <= ($urandom_range(0, 3) == 0);
					else
						out_stall <= ($urandom_range(0, 3) != 0);
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int guard;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle ticks are ignored; one measurement at the reset settings
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		measure_echo(2, 1);

		// zero trigger length gives a single trigger tick; echo ignored on it
		program_ranger(0, 65535);
		send_tick(1'b1, 1'b1);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b1);
		send_tick(1'b0, 1'b0);
		// fill the ring so the average takes over
		for (int n = 2; n <= 5; n++)
			measure_echo(0, n);

		random_phase(1, 1, 150);
		random_phase(255, 40000, 280);
		random_phase(3, 0, 120);
		random_phase(98, 11509, 200);

		repeat (4) random_phase($urandom_range(1, 12), $urandom_range(1, 65535), 80);

		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (pending_ticks != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		if (fails == 0 && pending_ticks == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
